/* hw/rtl/cordic_atan2_vectoring_core_assert.svh */
// Assertion macros for the CORDIC atan2 core
`ifndef CORDIC_ATAN2_VECTORING_CORE_ASSERT_SVH
`define CORDIC_ATAN2_VECTORING_CORE_ASSERT_SVH

// check with the reset masking the property
`define CAV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs while reset is high
`define CAV_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/cordic_pkg.sv */
`timescale 1ns / 1ps
package cordic_pkg;

   localparam int ITERATIONS = 15;
   localparam int IN_W       = 16;
   localparam int ANGLE_W    = 16;
   localparam int DATA_W     = IN_W + 4;
   localparam int IDX_W      = 4;
   localparam int LATENCY    = ITERATIONS + 2;

   localparam logic [ANGLE_W-1:0] HALF_TURN = {1'b1, {(ANGLE_W-1){1'b0}}};

   typedef struct packed {
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  y;
      logic signed [ANGLE_W-1:0] z;
      logic                      x_neg;
      logic                      y_neg;
      logic                      zero;
   } stage_type;

   function automatic logic signed [ANGLE_W-1:0] atan_unit(input logic [IDX_W-1:0] idx);
      logic signed [ANGLE_W-1:0] val;
      unique case (idx)
         4'd0:    val = 16'sd8192;
         4'd1:    val = 16'sd4836;
         4'd2:    val = 16'sd2555;
         4'd3:    val = 16'sd1297;
         4'd4:    val = 16'sd651;
         4'd5:    val = 16'sd326;
         4'd6:    val = 16'sd163;
         4'd7:    val = 16'sd81;
         4'd8:    val = 16'sd41;
         4'd9:    val = 16'sd20;
         4'd10:   val = 16'sd10;
         4'd11:   val = 16'sd5;
         4'd12:   val = 16'sd3;
         4'd13:   val = 16'sd1;
         4'd14:   val = 16'sd1;
         default: val = 16'sd0;
      endcase
      return val;
   endfunction

endpackage

/* hw/rtl/cordic_atan2_vectoring_core.sv */
`timescale 1ns / 1ps
// channel    ports                                  handshake
// request    start, busy, req_y_in, req_x_in        taken when start && !busy
// response   rsp_valid, rsp_angle_out               one-cycle strobe, no backpressure
//
// One request per cycle, sustained; busy stays low.
// Pipeline from the accepting edge to the result, in order:
// one input stage, one stage per CORDIC micro-rotation (15), one quadrant stage.
// Synchronous reset clears the valid bits; requests in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module cordic_atan2_vectoring_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [cordic_pkg::IN_W-1:0]    req_y_in,
   input  logic signed [cordic_pkg::IN_W-1:0]    req_x_in,
   output logic                                 rsp_valid,
   output logic signed [cordic_pkg::ANGLE_W-1:0] rsp_angle_out
);
   import cordic_pkg::*;

   stage_type                 stage_in [0:ITERATIONS];
   stage_type                 stage_ff [0:ITERATIONS];
   logic [ITERATIONS+1:0]     valid_in;
   logic [ITERATIONS+1:0]     valid_ff;
   logic signed [DATA_W-1:0]  y_ext;
   logic signed [DATA_W-1:0]  x_ext;
   logic [ANGLE_W-1:0]        z_last;
   logic [ANGLE_W-1:0]        angle_in;
   logic [ANGLE_W-1:0]        angle_ff;

   assign busy = 1'b0;

   always_comb begin
      y_ext = DATA_W'(req_y_in);
      x_ext = DATA_W'(req_x_in);
      stage_in[0].x_neg = req_x_in[IN_W-1];
      stage_in[0].y_neg = req_y_in[IN_W-1];
      stage_in[0].zero  = (req_x_in == '0) && (req_y_in == '0);
      stage_in[0].x     = req_x_in[IN_W-1] ? -x_ext : x_ext;
      stage_in[0].y     = req_y_in[IN_W-1] ? -y_ext : y_ext;
      stage_in[0].z     = '0;
   end

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
      always_comb begin
         stage_in[i+1] = stage_ff[i];
         if (!stage_ff[i].y[DATA_W-1]) begin
            stage_in[i+1].x = stage_ff[i].x + (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y - (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z + atan_unit(IDX_W'(i));
         end else begin
            stage_in[i+1].x = stage_ff[i].x - (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y + (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z - atan_unit(IDX_W'(i));
         end
      end
   end

   always_comb begin
      z_last = stage_ff[ITERATIONS].z;
      priority if (stage_ff[ITERATIONS].zero) begin
         angle_in = '0;
      end else if (stage_ff[ITERATIONS].x_neg && !stage_ff[ITERATIONS].y_neg) begin
         angle_in = HALF_TURN - z_last;
      end else if (stage_ff[ITERATIONS].x_neg) begin
         angle_in = z_last - HALF_TURN;
      end else if (stage_ff[ITERATIONS].y_neg) begin
         angle_in = -z_last;
      end else begin
         angle_in = z_last;
      end
   end

   assign valid_in = {valid_ff[ITERATIONS:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= ITERATIONS; k++) begin
         stage_ff[k] <= stage_in[k];
      end
      angle_ff <= angle_in;
   end

   assign rsp_valid     = valid_ff[ITERATIONS+1];
   assign rsp_angle_out = angle_ff;

endmodule

/* hw/rtl/cordic_atan2_vectoring_core_checker.sv */
`timescale 1ns / 1ps
`include "cordic_atan2_vectoring_core_assert.svh"
module cordic_atan2_vectoring_core_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic signed [cordic_pkg::IN_W-1:0]    req_y_in,
   input logic signed [cordic_pkg::IN_W-1:0]    req_x_in,
   input logic                                 rsp_valid,
   input logic signed [cordic_pkg::ANGLE_W-1:0] rsp_angle_out
);
   import cordic_pkg::*;

   localparam int LAT = LATENCY;

   `CAV_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "response after reset")
   `CAV_ASSERT(a_latency, clock, reset, (start && !busy) |-> ##LAT rsp_valid, "response missing")
   `CAV_ASSERT(a_no_spurious, clock, reset, !(start && !busy) |-> ##LAT !rsp_valid, "extra response")
   `CAV_ASSERT(a_zero_vec, clock, reset, (start && !busy && req_y_in == '0 && req_x_in == '0) |-> ##LAT (rsp_angle_out == '0), "zero vector angle")

endmodule

bind cordic_atan2_vectoring_core cordic_atan2_vectoring_core_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_y_in      (req_y_in),
   .req_x_in      (req_x_in),
   .rsp_valid     (rsp_valid),
   .rsp_angle_out (rsp_angle_out)
);
